### rtl/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/tlsf_pkg.sv
// Types and constants of the tabu list similarity filter.
package tlsf_pkg;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int MAX_GENES_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [4:0]  TABU_LENGTH_RST = 5'd16;
    localparam logic [15:0] TOLERANCE_RST   = 16'd655;

    typedef enum logic [1:0] {
        KIND_REAL = 2'd0,
        KIND_INT  = 2'd1,
        KIND_BIT  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_FLOAT_COUNT = 3'd0,
        REG_INT_COUNT   = 3'd1,
        REG_BOOL_COUNT  = 3'd2,
        REG_TABU_LENGTH = 3'd3,
        REG_THRESHOLD   = 3'd4,
        REG_TOLERANCE   = 3'd5
    } t_reg;

    typedef struct packed {
        logic [6:0]  float_count;
        logic [6:0]  int_count;
        logic [6:0]  bool_count;
        logic [4:0]  tabu_length;
        logic [17:0] threshold;
        logic [15:0] tolerance;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL,
        ST_RD,
        ST_CMP,
        ST_CHK,
        ST_DEC,
        ST_CP_RD,
        ST_CP_WR,
        ST_UPD,
        ST_DONE
    } t_state;
endpackage

### rtl/tlsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tlsf_regs.sv
// Configuration register file behind the APB-style port.
module tlsf_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tlsf_pkg::t_cfg     o_cfg
);
    import tlsf_pkg::*;

    t_cfg r_cfg;
    logic w_wr;
    t_reg w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.float_count <= '0;
            r_cfg.int_count   <= '0;
            r_cfg.bool_count  <= '0;
            r_cfg.tabu_length <= TABU_LENGTH_RST;
            r_cfg.threshold   <= '0;
            r_cfg.tolerance   <= TOLERANCE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FLOAT_COUNT: r_cfg.float_count <= pwdata[6:0];
                REG_INT_COUNT:   r_cfg.int_count   <= pwdata[6:0];
                REG_BOOL_COUNT:  r_cfg.bool_count  <= pwdata[6:0];
                REG_TABU_LENGTH: r_cfg.tabu_length <= pwdata[4:0];
                REG_THRESHOLD:   r_cfg.threshold   <= pwdata[17:0];
                REG_TOLERANCE:   r_cfg.tolerance   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FLOAT_COUNT: prdata = {25'd0, r_cfg.float_count};
            REG_INT_COUNT:   prdata = {25'd0, r_cfg.int_count};
            REG_BOOL_COUNT:  prdata = {25'd0, r_cfg.bool_count};
            REG_TABU_LENGTH: prdata = {27'd0, r_cfg.tabu_length};
            REG_THRESHOLD:   prdata = {14'd0, r_cfg.threshold};
            REG_TOLERANCE:   prdata = {16'd0, r_cfg.tolerance};
            default:         prdata = '0;
        endcase
    end
endmodule

### rtl/tlsf_gene_cmp.sv
// Gene match test for one pair of values of a given section.
module tlsf_gene_cmp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [1:0]             i_kind,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    input  logic [15:0]            i_tol,
    output logic                   o_match
);
    import tlsf_pkg::*;

    localparam int DW = (VALUE_WIDTH + 1 > 17) ? VALUE_WIDTH + 1 : 17;

    logic signed [DW-1:0] w_a, w_b, w_d;
    logic        [DW-1:0] w_abs;

    assign w_a   = DW'(signed'(i_a));
    assign w_b   = DW'(signed'(i_b));
    assign w_d   = w_a - w_b;
    assign w_abs = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);

    always_comb begin
        case (t_kind'(i_kind))
            KIND_REAL: o_match = w_abs < {{(DW-16){1'b0}}, i_tol};
            KIND_INT:  o_match = i_a == i_b;
            KIND_BIT:  o_match = i_a[0] == i_b[0];
            default:   o_match = 1'b0;
        endcase
    end
endmodule

### rtl/tabu_list_similarity_filter.sv
// Top level: tabu list similarity filter with entry and candidate memories.
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------
// element   | in        | start & !busy             | i_kind i_value i_last i_improves
// verdict   | out       | o_done (one-cycle strobe) | o_is_tabu o_stored o_entries_held
// config    | in        | psel penable pwrite       | paddr pwdata, read back on prdata
//
// A non-last element leaves busy low. After a last element, busy stays high up to the
// result state. Per held entry: a select state per section, read and compare states per
// gene and a check state where the section has genes, and a select state to close the
// entry. Then a select state ends the sweep (a hit skips it and the remaining entries), a
// decide state, read and write copy states per candidate word and an update state when the
// candidate is pushed, and the result state. The entry memory has a single read port.
// Reset is synchronous and active low; no clearing pass. The result cannot be stalled.
module tabu_list_similarity_filter #(
    parameter int MAX_ENTRIES = tlsf_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_GENES   = tlsf_pkg::MAX_GENES_DEF,
    parameter int VALUE_WIDTH = tlsf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_kind,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_last,
    input  logic                   i_improves,
    output logic                   o_done,
    output logic                   o_is_tabu,
    output logic                   o_stored,
    output logic [4:0]             o_entries_held,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import tlsf_pkg::*;

    `include "assert_macros.svh"

    localparam int SEC_WORDS = 3 * MAX_GENES;
    localparam int EDEPTH    = MAX_ENTRIES * SEC_WORDS;
    localparam int CAW       = (SEC_WORDS > 1) ? $clog2(SEC_WORDS) : 1;
    localparam int EAW       = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
    localparam int GW        = $clog2(MAX_GENES + 1);
    localparam int EW        = $clog2(MAX_ENTRIES + 1);
    localparam int SLW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW        = 18 + GW;

    t_cfg   w_cfg;
    t_state r_state, n_state;

    logic [GW-1:0]  r_pos [3];
    logic [GW-1:0]  w_n [4];
    logic [EW-1:0]  w_len;
    logic [EW-1:0]  r_count, r_e;
    logic [SLW-1:0] r_oldest, r_slot;
    logic [1:0]     r_k;
    logic [GW-1:0]  r_i, r_match, w_pos_cur;
    logic [PW-1:0]  r_prod;
    logic           r_tabu, r_stored, r_improves;

    logic                   w_accept, w_cwe, w_ewe, w_match, w_hit, w_push, w_full;
    logic [1:0]             w_kidx;
    logic [CAW-1:0]         w_cwaddr, w_craddr;
    logic [EAW-1:0]         w_eaddr;
    logic [VALUE_WIDTH-1:0] w_crdata, w_erdata, w_cval;

    tlsf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // effective counts, limited to MAX_GENES; index 3 is an empty section
    function automatic logic [GW-1:0] eff(input logic [6:0] c);
        if (32'(c) > MAX_GENES) return GW'(MAX_GENES);
        return GW'(c);
    endfunction

    function automatic logic [SLW-1:0] slot_add(input logic [SLW-1:0] a, input logic [EW-1:0] b);
        logic [31:0] s;
        s = 32'(a) + 32'(b);
        if (s >= MAX_ENTRIES) s = s - MAX_ENTRIES;
        return SLW'(s);
    endfunction

    assign w_n[0] = eff(w_cfg.float_count);
    assign w_n[1] = eff(w_cfg.int_count);
    assign w_n[2] = eff(w_cfg.bool_count);
    assign w_n[3] = '0;
    assign w_len  = (32'(w_cfg.tabu_length) > MAX_ENTRIES) ? EW'(MAX_ENTRIES)
                                                           : EW'(w_cfg.tabu_length);

    assign busy     = r_state != ST_IDLE;
    assign w_accept = start && !busy;
    assign w_kidx   = i_kind;

    always_comb begin
        w_cwe = 1'b0;
        if (w_accept && w_kidx != 2'd3) begin
            w_cwe = r_pos[w_kidx] < w_n[w_kidx];
        end
    end

    always_comb begin
        case (r_k)
            2'd0:    w_pos_cur = r_pos[0];
            2'd1:    w_pos_cur = r_pos[1];
            2'd2:    w_pos_cur = r_pos[2];
            default: w_pos_cur = '0;
        endcase
    end

    assign w_cwaddr = (w_kidx != 2'd3) ?
                      CAW'(32'(w_kidx) * MAX_GENES + 32'(r_pos[w_kidx])) : '0;
    assign w_craddr = CAW'(32'(r_k) * MAX_GENES + 32'(r_i));
    assign w_eaddr  = EAW'(32'(r_slot) * SEC_WORDS + 32'(r_k) * MAX_GENES + 32'(r_i));
    assign w_ewe    = r_state == ST_CP_WR;
    // genes never supplied for this candidate read as zero
    assign w_cval   = (r_i < w_pos_cur) ? w_crdata : '0;

    tlsf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SEC_WORDS)) u_cand_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwaddr),
        .i_wdata (i_value),
        .i_raddr (w_craddr),
        .o_rdata (w_crdata)
    );

    tlsf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(EDEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ewe),
        .i_waddr (w_eaddr),
        .i_wdata (w_cval),
        .i_raddr (w_eaddr),
        .o_rdata (w_erdata)
    );

    tlsf_gene_cmp #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmp (
        .i_kind  (r_k),
        .i_a     (w_cval),
        .i_b     (w_erdata),
        .i_tol   (w_cfg.tolerance),
        .o_match (w_match)
    );

    assign w_hit  = 64'({r_match, 16'd0}) > 64'(r_prod);
    assign w_full = 32'(r_count) + 1 > 32'(w_len);
    assign w_push = !r_tabu && r_improves && (!w_full || r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept && i_last) n_state = ST_SEL;
            ST_SEL: begin
                if (r_e >= r_count) begin
                    n_state = ST_DEC;
                end else if (r_k != 2'd3 && w_n[r_k] != '0) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:    n_state = ST_CMP;
            ST_CMP:   n_state = (32'(r_i) + 1 == 32'(w_n[r_k])) ? ST_CHK : ST_RD;
            ST_CHK:   n_state = w_hit ? ST_DEC : ST_SEL;
            ST_DEC:   n_state = w_push ? ST_CP_RD : ST_DONE;
            ST_CP_RD: n_state = ST_CP_WR;
            ST_CP_WR: begin
                if (32'(r_i) == MAX_GENES - 1 && r_k == 2'd2) n_state = ST_UPD;
                else n_state = ST_CP_RD;
            end
            ST_UPD:   n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sweep and list bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_pos    <= '{default: '0};
            r_e      <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_match  <= '0;
            r_tabu   <= 1'b0;
            r_stored <= 1'b0;
            r_slot   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_cwe) r_pos[w_kidx] <= r_pos[w_kidx] + 1'b1;
                    if (w_accept && i_last) begin
                        r_improves <= i_improves;
                        r_e        <= '0;
                        r_k        <= '0;
                        r_tabu     <= 1'b0;
                    end
                end
                ST_SEL: begin
                    if (r_e < r_count) begin
                        if (r_k == 2'd3) begin
                            r_e <= r_e + 1'b1;
                            r_k <= '0;
                        end else if (w_n[r_k] == '0) begin
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_i     <= '0;
                            r_match <= '0;
                            r_slot  <= slot_add(r_oldest, r_e);
                        end
                    end
                end
                ST_CMP: begin
                    r_match <= r_match + GW'(w_match);
                    r_i     <= r_i + 1'b1;
                end
                ST_CHK: begin
                    if (w_hit) r_tabu <= 1'b1;
                    else r_k <= r_k + 1'b1;
                end
                ST_DEC: begin
                    r_stored <= w_push;
                    r_k      <= '0;
                    r_i      <= '0;
                    r_slot   <= slot_add(r_oldest, r_count);
                end
                ST_CP_WR: begin
                    if (32'(r_i) == MAX_GENES - 1) begin
                        r_i <= '0;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_UPD: begin
                    if (w_full) r_oldest <= slot_add(r_oldest, EW'(1));
                    else r_count <= r_count + 1'b1;
                end
                ST_DONE: r_pos <= '{default: '0};
                default: ;
            endcase
        end
    end

    // threshold times count of the section under test, ready by the check cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_cfg.threshold) * PW'(w_n[r_k]);
    end

    assign o_done         = r_state == ST_DONE;
    assign o_is_tabu      = r_tabu;
    assign o_stored       = r_stored;
    assign o_entries_held = 5'(32'(r_count));

    `ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, 32'(r_count) <= MAX_ENTRIES)
    `ASSERT_IMP(a_tabu_not_stored, i_clk, i_rst_n, o_done, !(o_is_tabu && o_stored))
    `ASSERT_NXT(a_last_busy, i_clk, i_rst_n, w_accept && i_last, busy)
    `ASSERT_IMP(a_copy_only_push, i_clk, i_rst_n, w_ewe, !r_tabu && r_improves)
endmodule
